// ----- rtl/core/ssff_pkg.sv -----
`default_nettype none

package ssff_pkg;

	localparam logic [1:0] CMD_STORE  = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_ADD    = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OCCUPIED = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  slot_index;
		logic [31:0] payload_in;
	} ssff_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot_used;
		logic [31:0] payload_out;
		logic [4:0]  occupied_count;
		logic        table_full;
	} ssff_out_t;

	// outcome of one command, everything but the payload read back
	typedef struct packed {
		logic [1:0] status;
		logic [3:0] slot_used;
		logic [4:0] occupied_count;
		logic       table_full;
		logic       mem_wr;
		logic       mem_rd;
	} ssff_dec_t;

endpackage

`default_nettype wire

// ----- rtl/core/ssff_ram.sv -----
`default_nettype none

module ssff_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ssff_alloc.sv -----
`default_nettype none

module ssff_alloc #(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire ssff_pkg::ssff_in_t           cmd,
	output ssff_pkg::ssff_dec_t               dec,
	output logic [$clog2(NUM_SLOTS)-1:0]      mem_addr
);

	import ssff_pkg::*;

	localparam int IW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(NUM_SLOTS + 1);

	logic [NUM_SLOTS-1:0] occ_q;
	logic [NUM_SLOTS-1:0] occ_nxt;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_nxt;
	logic [IW-1:0]        idx_w;
	logic [IW-1:0]        free_idx;
	logic                 free_found;
	logic                 in_range;
	logic                 is_full;

	assign idx_w    = IW'(cmd.slot_index);
	assign in_range = 32'(cmd.slot_index) < 32'(NUM_SLOTS);
	assign is_full  = count_q == CW'(NUM_SLOTS);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!occ_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	always_comb begin
		occ_nxt       = occ_q;
		count_nxt     = count_q;
		mem_addr      = idx_w;
		dec.status    = ST_OK;
		dec.slot_used = '0;
		dec.mem_wr    = 1'b0;
		dec.mem_rd    = 1'b0;
		unique case (cmd.command)
			CMD_STORE: begin
				dec.slot_used = cmd.slot_index;
				if (!in_range || occ_q[idx_w]) begin
					dec.status = ST_OCCUPIED;
				end else begin
					occ_nxt[idx_w] = 1'b1;
					count_nxt      = count_q + CW'(1);
					dec.mem_wr     = 1'b1;
				end
			end
			CMD_REMOVE: begin
				dec.slot_used = cmd.slot_index;
				if (!in_range || !occ_q[idx_w]) begin
					dec.status = ST_EMPTY;
				end else begin
					occ_nxt[idx_w] = 1'b0;
					count_nxt      = count_q - CW'(1);
					dec.mem_rd     = 1'b1;
				end
			end
			CMD_ADD: begin
				if (is_full || !free_found) begin
					dec.status = ST_FULL;
				end else begin
					occ_nxt[free_idx] = 1'b1;
					count_nxt         = count_q + CW'(1);
					mem_addr          = free_idx;
					dec.slot_used     = 4'(free_idx);
					dec.mem_wr        = 1'b1;
				end
			end
			default: begin
				// unused code: no change, report as things stand
			end
		endcase
		dec.occupied_count = 5'(count_nxt);
		dec.table_full     = count_nxt == CW'(NUM_SLOTS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			occ_q   <= occ_nxt;
			count_q <= count_nxt;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/slot_store_first_free_alloc.sv -----
// First-free slot allocator. Takes one command per clock (store at a slot, remove from
// a slot, add at the lowest free slot) while the result side is not stalled, and gives
// exactly one result per command, via the decision stage and output register. Occupancy
// bits and the occupied count sit in flops, so the next command sees the previous one's
// effect at once, and a priority encoder over the occupancy bits finds the first free
// slot within the cycle. Payloads live in a simple dual-port RAM (one write, one
// registered read); a successful remove reads its slot in the decision stage and the
// word joins the result on its way into the output register. No command both writes
// and reads the RAM, so back-to-back commands need no forwarding. Occupancy is cleared
// by reset; the payload RAM is not cleared and needs no sweep. The output
// register keeps one finished result waiting while the next command is taken.
`default_nettype none

module slot_store_first_free_alloc #(
	parameter int NUM_SLOTS     = 16,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire ssff_pkg::ssff_in_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output ssff_pkg::ssff_out_t      out_data
);

	import ssff_pkg::*;

	localparam int IW = $clog2(NUM_SLOTS);

	logic                     in_beat;
	logic                     adv_s1;
	logic                     v_s1;
	ssff_dec_t                dec;
	ssff_dec_t                dec_s1;
	logic [IW-1:0]            mem_addr;
	logic [PAYLOAD_WIDTH-1:0] ram_rdata;

	assign adv_s1   = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || adv_s1;
	assign in_beat  = in_valid && in_ready;

	ssff_alloc #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_alloc (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_beat),
		.cmd     (in_data),
		.dec     (dec),
		.mem_addr(mem_addr)
	);

	// read data holds until the next remove beat, which only comes once s1 moves on
	ssff_ram #(
		.WIDTH(PAYLOAD_WIDTH),
		.DEPTH(NUM_SLOTS)
	) u_payload_ram (
		.clk  (clk),
		.we   (in_beat && dec.mem_wr),
		.waddr(mem_addr),
		.wdata(PAYLOAD_WIDTH'(in_data.payload_in)),
		.re   (in_beat && dec.mem_rd),
		.raddr(mem_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			dec_s1 <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data.status         <= dec_s1.status;
			out_data.slot_used      <= dec_s1.slot_used;
			out_data.payload_out    <= dec_s1.mem_rd ? 32'(ram_rdata) : 32'd0;
			out_data.occupied_count <= dec_s1.occupied_count;
			out_data.table_full     <= dec_s1.table_full;
		end
	end

`ifndef SYNTHESIS
	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && dec_s1.status == ST_FULL |-> dec_s1.table_full)
		else $error("table full reported without full flag");

	a_wr_rd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && dec.mem_wr |-> !dec.mem_rd && dec.status == ST_OK)
		else $error("payload write with a read or a failed status");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv_s1 |=> v_s1 && $stable(dec_s1))
		else $error("stalled decision stage changed");
`endif

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ssff_pkg::*;

	localparam int SLOT_COUNT = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	ssff_in_t in_data;
	logic out_valid;
	logic out_ready;
	ssff_out_t out_data;

	// predictor state
	bit slot_taken [SLOT_COUNT];
	logic [31:0] slot_word [SLOT_COUNT];
	int taken_count;
	ssff_out_t pending_results [$];

	int cmd_tally [4];
	int status_tally [4];
	int mismatches;
	int cycle_count;
	bit in_gaps_on;
	bit out_stalls_on;
	int stall_hold;
	ssff_out_t want;

	slot_store_first_free_alloc DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d results outstanding", $time,
				pending_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic ssff_out_t predict_slot_op(ssff_in_t c);
		ssff_out_t r;
		int first_free;
		r = '0;
		first_free = -1;
		cmd_tally[c.command]++;
		case (c.command)
			CMD_STORE: begin
				r.slot_used = c.slot_index;
				if (slot_taken[c.slot_index]) begin
					r.status = ST_OCCUPIED;
				end else begin
					slot_taken[c.slot_index] = 1'b1;
					slot_word[c.slot_index] = c.payload_in;
					taken_count++;
					r.status = ST_OK;
				end
			end
			CMD_REMOVE: begin
				r.slot_used = c.slot_index;
				if (!slot_taken[c.slot_index]) begin
					r.status = ST_EMPTY;
				end else begin
					slot_taken[c.slot_index] = 1'b0;
					r.payload_out = slot_word[c.slot_index];
					taken_count--;
					r.status = ST_OK;
				end
			end
			CMD_ADD: begin
				for (int s = SLOT_COUNT - 1; s >= 0; s--)
					if (!slot_taken[s])
						first_free = s;
				if (first_free < 0) begin
					r.status = ST_FULL;
				end else begin
					slot_taken[first_free] = 1'b1;
					slot_word[first_free] = c.payload_in;
					taken_count++;
					r.slot_used = 4'(first_free);
					r.status = ST_OK;
				end
			end
			default: ;
		endcase
		r.occupied_count = 5'(taken_count);
		r.table_full = (taken_count == SLOT_COUNT);
		status_tally[r.status]++;
		return r;
	endfunction

	function automatic logic [3:0] pick_slot(bit want_taken);
		logic [3:0] cands [$];
		for (int s = 0; s < SLOT_COUNT; s++)
			if (slot_taken[s] == want_taken)
				cands.push_back(4'(s));
		if (cands.size() == 0)
			return 4'($urandom_range(0, SLOT_COUNT - 1));
		return cands[$urandom_range(0, cands.size() - 1)];
	endfunction

	// valid stays up across back-to-back beats, dropped only when a gap starts
	task automatic send_slot_cmd(input logic [1:0] cmd, input logic [3:0] idx,
			input logic [31:0] word);
		int gap;
		ssff_in_t beat;
		gap = in_gaps_on ? idle_gap() : 0;
		beat.command = cmd;
		beat.slot_index = idx;
		beat.payload_in = word;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(predict_slot_op(beat));
	endtask

	task automatic send_random_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			send_slot_cmd(CMD_ADD, 4'($urandom), $urandom);
		end else if (r < 65) begin
			if ($urandom_range(0, 4) != 0)
				send_slot_cmd(CMD_REMOVE, pick_slot(1'b1), $urandom);
			else
				send_slot_cmd(CMD_REMOVE, 4'($urandom), $urandom);
		end else if (r < 95) begin
			if ($urandom_range(0, 3) != 0)
				send_slot_cmd(CMD_STORE, pick_slot(1'b0), $urandom);
			else
				send_slot_cmd(CMD_STORE, 4'($urandom), $urandom);
		end else begin
			send_slot_cmd(CMD_UNUSED, 4'($urandom), $urandom);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name,
				want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected, got %p", $time, out_data);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, out_data.status);
				check_field("slot_used", want.slot_used, out_data.slot_used);
				check_field("payload_out", want.payload_out, out_data.payload_out);
				check_field("occupied_count", want.occupied_count, out_data.occupied_count);
				check_field("table_full", want.table_full, out_data.table_full);
			end
		end
	end

	// result side: with stalls on, runs of ready broken by stalls of random length; else always ready
	initial begin
		out_ready = 1'b0;
		stall_hold = 0;
		forever begin
			@(negedge clk);
			if (!out_stalls_on) begin
				out_ready <= 1'b1;
			end else if (stall_hold != 0) begin
				stall_hold--;
			end else if (out_ready) begin
				out_ready <= 1'b0;
				stall_hold = idle_gap();
			end else begin
				out_ready <= 1'b1;
				stall_hold = $urandom_range(0, 6);
			end
		end
	end

	task automatic test_directed_cases();
		send_slot_cmd(CMD_REMOVE, 4'd0, 32'h0);
		send_slot_cmd(CMD_REMOVE, 4'd15, 32'hffff_ffff);
		send_slot_cmd(CMD_UNUSED, 4'd15, 32'hffff_ffff);
		send_slot_cmd(CMD_ADD, 4'd9, 32'hffff_ffff);
		send_slot_cmd(CMD_STORE, 4'd0, 32'h1234_5678);
		send_slot_cmd(CMD_STORE, 4'd15, 32'h0);
		// fill the middle slots through the first-free search
		for (int s = 1; s < SLOT_COUNT - 1; s++)
			send_slot_cmd(CMD_ADD, 4'($urandom), $urandom);
		send_slot_cmd(CMD_ADD, 4'd0, 32'hdead_beef);
		send_slot_cmd(CMD_STORE, 4'd7, 32'ha5a5_a5a5);
		send_slot_cmd(CMD_REMOVE, 4'd15, 32'h0);
		send_slot_cmd(CMD_REMOVE, 4'd0, 32'h0);
		send_slot_cmd(CMD_ADD, 4'd15, 32'h5a5a_5a5a);
	endtask

	task automatic test_random_mix(input int n);
		repeat (n)
			send_random_cmd();
	endtask

	task automatic test_fill_and_drain(input int rounds);
		repeat (rounds) begin
			while (taken_count < SLOT_COUNT) begin
				if ($urandom_range(0, 1))
					send_slot_cmd(CMD_ADD, 4'($urandom), $urandom);
				else
					send_slot_cmd(CMD_STORE, pick_slot(1'b0), $urandom);
			end
			send_slot_cmd(CMD_ADD, 4'($urandom), $urandom);
			while (taken_count > 0) begin
				if ($urandom_range(0, 7) == 0)
					send_slot_cmd(CMD_REMOVE, pick_slot(1'b0), $urandom);
				else
					send_slot_cmd(CMD_REMOVE, pick_slot(1'b1), $urandom);
			end
		end
	endtask

	task automatic test_full_rate(input int n);
		in_gaps_on = 1'b0;
		out_stalls_on = 1'b0;
		test_random_mix(n);
		out_stalls_on = 1'b1;
		test_random_mix(n);
		in_gaps_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		in_gaps_on = 1'b1;
		out_stalls_on = 1'b1;
		taken_count = 0;
		mismatches = 0;
		cycle_count = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_random_mix(200);
		test_fill_and_drain(3);
		test_full_rate(60);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("ran %0d stores, %0d removes, %0d adds, %0d unused-code commands",
			cmd_tally[CMD_STORE], cmd_tally[CMD_REMOVE], cmd_tally[CMD_ADD],
			cmd_tally[CMD_UNUSED]);
		$display("outcomes: %0d ok, %0d occupied, %0d empty, %0d full",
			status_tally[ST_OK], status_tally[ST_OCCUPIED], status_tally[ST_EMPTY],
			status_tally[ST_FULL]);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/ssff_pkg.sv
rtl/core/ssff_ram.sv
rtl/core/ssff_alloc.sv
rtl/core/slot_store_first_free_alloc.sv
dv/testbench.sv
